// ===== hdl/systematic_resampler_core_assert.svh =====
// Assertion macros for the systematic resampler.
`ifndef SYSTEMATIC_RESAMPLER_CORE_ASSERT_SVH
`define SYSTEMATIC_RESAMPLER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SR_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define SR_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define SR_ASSERT_IMP(label, clk, rst_n, a, c)
`define SR_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== hdl/sresamp_pkg.sv =====
`default_nettype none
package sresamp_pkg;
    localparam int MaxParticles = 64;
    localparam int IdxW = $clog2(MaxParticles);
    localparam int CntW = IdxW + 1;

    typedef struct packed {
        logic signed [15:0] log_weight;
        logic [15:0]        uniform_offset;
        logic               is_last;
    } req_t;

    typedef struct packed {
        logic [5:0] particle_index;
        logic       last_index;
    } res_t;

    // Q16 table of 2^(-i/16).
    function automatic logic [16:0] exp2_tab(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0: v = 17'd65536;   5'd1: v = 17'd62757;  5'd2: v = 17'd60097;
            5'd3: v = 17'd57549;   5'd4: v = 17'd55109;  5'd5: v = 17'd52773;
            5'd6: v = 17'd50535;   5'd7: v = 17'd48393;  5'd8: v = 17'd46341;
            5'd9: v = 17'd44376;   5'd10: v = 17'd42495; 5'd11: v = 17'd40693;
            5'd12: v = 17'd38968;  5'd13: v = 17'd37316; 5'd14: v = 17'd35734;
            5'd15: v = 17'd34219;  default: v = 17'd32768;
        endcase
        return v;
    endfunction

    // Q16 table of log2(1 + i/16).
    function automatic logic [16:0] log2_tab(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0: v = 17'd0;      5'd1: v = 17'd5732;   5'd2: v = 17'd11136;
            5'd3: v = 17'd16248;  5'd4: v = 17'd21098;  5'd5: v = 17'd25711;
            5'd6: v = 17'd30109;  5'd7: v = 17'd34312;  5'd8: v = 17'd38336;
            5'd9: v = 17'd42196;  5'd10: v = 17'd45904; 5'd11: v = 17'd49472;
            5'd12: v = 17'd52911; 5'd13: v = 17'd56229; 5'd14: v = 17'd59434;
            5'd15: v = 17'd62534; default: v = 17'd65536;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/sresamp_exp.sv =====
`default_nettype none
// Pipelined exp(-a): multiply, then table interpolation, then shift.
// Accepts one operand per cycle.
module sresamp_exp (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [17:0] a,
    output logic             out_valid,
    output logic [16:0]      y
);
    logic [3:0]  vld_reg;
    logic [34:0] prod_reg;
    logic [16:0] t0_reg;
    logic [16:0] t1_reg;
    logic [16:0] diff_reg;
    logic [11:0] r_reg;
    logic [10:0] k1_reg;
    logic [28:0] mul_reg;
    logic [10:0] k2_reg;
    logic [16:0] y_reg;
    logic [10:0] k0;
    logic [3:0]  idx;
    logic [16:0] v;

    assign k0  = prod_reg[34:24];
    assign idx = prod_reg[23:20];
    assign v   = t1_reg - mul_reg[28:12];

    // Valid pipe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // Data pipe.
    always_ff @(posedge clk)
    begin
        prod_reg <= 35'(a) * 35'd94548;
        t0_reg   <= sresamp_pkg::exp2_tab({1'b0, idx});
        diff_reg <= sresamp_pkg::exp2_tab({1'b0, idx})
                    - sresamp_pkg::exp2_tab(5'({1'b0, idx}) + 5'd1);
        r_reg    <= prod_reg[19:8];
        k1_reg   <= k0;
        t1_reg   <= t0_reg;
        mul_reg  <= 29'(diff_reg) * 29'(r_reg);
        k2_reg   <= k1_reg;
        y_reg    <= (k2_reg > 11'd16) ? 17'd0 : (v >> k2_reg[4:0]);
    end

    assign out_valid = vld_reg[3];
    assign y = y_reg;
endmodule
`default_nettype wire

// ===== hdl/systematic_resampler_core.sv =====
`default_nettype none
// Systematic resampler for a particle filter on signed Q8.8 log weights.
// A request is accepted when start is high and busy is low; each carries
// one log weight, stored in an on-chip memory of 64 entries while the
// maximum is kept; weights past the 64th are dropped. The request with
// is_last set also gives the uniform offset and starts a run: a first pass
// through the memory sums exp(w - max), a log unit forms ln of the sum,
// and a second pass accumulates the normalised weights and emits indices.
// The first pass streams the weights through the registered memory read and
// the four-stage exp pipeline. The second pass handles one weight at a
// time. busy stays high throughout a run. Every result appears for one
// cycle with result_valid; the receiver cannot stall.
// particle_count is to be written through cfg_valid/cfg_ready only while
// idle; the block itself does not enforce this. cfg_ready is always high.
// Reset clears the load count, sets the maximum to -32768 and the count
// to 64; the weight memory needs no clearing.
module systematic_resampler_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sresamp_pkg::req_t request,
    output logic                   result_valid,
    output sresamp_pkg::res_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [6:0]        cfg_data
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_SUM, ST_LOG, ST_WALK, ST_EMIT, ST_FILL
    } state_t;

    localparam int IdxW = sresamp_pkg::IdxW;
    localparam int CntW = sresamp_pkg::CntW;

    state_t               state_reg;
    logic [6:0]           count_reg;
    logic [CntW-1:0]      load_reg;
    logic signed [15:0]   max_reg;
    logic [15:0]          u_reg;
    logic [CntW-1:0]      nrun_reg;
    logic [CntW-1:0]      rd_reg;
    logic [CntW-1:0]      got_reg;
    logic [CntW-1:0]      emit_reg;
    logic [23:0]          sum_reg;
    logic [15:0]          lns_reg;
    logic [23:0]          c_reg;
    logic [2:0]           lstep_reg;
    logic [4:0]           p_reg;
    logic [16:0]          m_reg;
    logic [16:0]          frac_reg;
    logic [32:0]          l2_reg;
    logic                 rvld_reg;
    logic signed [15:0]   rdata_reg;
    logic                 res_vld_reg;
    sresamp_pkg::res_t    res_reg;

    logic signed [15:0]   mem [sresamp_pkg::MaxParticles];

    logic                 accept;
    logic                 store_ok;
    logic [17:0]          exp_a;
    logic                 exp_vld;
    logic [16:0]          exp_y;
    logic [CntW-1:0]      neff;
    logic                 slot_hit;
    logic [IdxW-1:0]      walk_idx;
    logic [16:0]          diff16;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign store_ok  = (load_reg < CntW'(sresamp_pkg::MaxParticles));

    // Effective slot count with range clamping.
    always_comb
    begin
        if (count_reg == 7'd0)
            neff = CntW'(1);
        else if (count_reg > 7'(sresamp_pkg::MaxParticles))
            neff = CntW'(sresamp_pkg::MaxParticles);
        else
            neff = CntW'(count_reg);
    end

    // Weight memory with registered read.
    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
            mem[load_reg[IdxW-1:0]] <= request.log_weight;
        rdata_reg <= mem[rd_reg[IdxW-1:0]];
    end

    // Exp operand: distance from the maximum plus ln of the sum on the walk.
    assign diff16 = 17'(max_reg) - 17'(rdata_reg);
    assign exp_a  = 18'(diff16) + ((state_reg == ST_WALK) ? 18'(lns_reg) : 18'd0);

    sresamp_exp u_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rvld_reg),
        .a        (exp_a),
        .out_valid(exp_vld),
        .y        (exp_y)
    );

    // Slot test: u + emitted * 65536 <= C * N.
    assign slot_hit = ({8'd0, u_reg} + {emit_reg, 16'd0}) <= 31'(c_reg) * 31'(nrun_reg);
    assign walk_idx = IdxW'(got_reg - CntW'(1));

    // Control and datapath sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= 7'd64;
            load_reg    <= '0;
            max_reg     <= -16'sd32768;
            rd_reg      <= '0;
            rvld_reg    <= 1'b0;
            got_reg     <= '0;
            emit_reg    <= '0;
            res_vld_reg <= 1'b0;
            lstep_reg   <= '0;
        end
        else
        begin
            res_vld_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_data;
            unique case (state_reg)
                ST_IDLE:
                begin
                    rvld_reg <= 1'b0;
                    if (accept)
                    begin
                        if (store_ok)
                        begin
                            load_reg <= load_reg + CntW'(1);
                            if (request.log_weight > max_reg)
                                max_reg <= request.log_weight;
                        end
                        if (request.is_last)
                        begin
                            if (store_ok)
                                nrun_reg <= load_reg + CntW'(1);
                            else
                                nrun_reg <= load_reg;
                            u_reg    <= request.uniform_offset;
                            rd_reg   <= '0;
                            got_reg  <= '0;
                            sum_reg  <= '0;
                            state_reg <= ST_SUM;
                        end
                    end
                end
                ST_SUM:
                begin
                    rvld_reg <= (rd_reg < load_reg);
                    if (rd_reg < load_reg)
                        rd_reg <= rd_reg + CntW'(1);
                    if (exp_vld)
                    begin
                        sum_reg <= sum_reg + 24'(exp_y);
                        got_reg <= got_reg + CntW'(1);
                        if (got_reg + CntW'(1) == load_reg)
                        begin
                            state_reg <= ST_LOG;
                            lstep_reg <= '0;
                            rvld_reg  <= 1'b0;
                        end
                    end
                end
                ST_LOG:
                begin
                    lstep_reg <= lstep_reg + 3'd1;
                    case (lstep_reg)
                        3'd0:
                        begin
                            p_reg <= 5'd16;
                            for (int b = 17; b < 24; b++)
                                if (sum_reg[b])
                                    p_reg <= 5'(b);
                        end
                        3'd1: m_reg <= 17'((sum_reg < 24'd65536 ? 24'd65536 : sum_reg)
                                            >> (p_reg - 5'd16));
                        3'd2: frac_reg <= sresamp_pkg::log2_tab({1'b0, m_reg[15:12]})
                            + 17'(((29'(sresamp_pkg::log2_tab(5'({1'b0, m_reg[15:12]}) + 5'd1))
                                 - 29'(sresamp_pkg::log2_tab({1'b0, m_reg[15:12]})))
                                 * 29'(m_reg[11:0])) >> 12);
                        3'd3: l2_reg <= 33'({p_reg - 5'd16, 16'd0}) + 33'(frac_reg);
                        3'd4: l2_reg <= 33'((42'(l2_reg) * 42'd45426) >> 24);
                        default:
                        begin
                            lns_reg   <= l2_reg[15:0];
                            rd_reg    <= '0;
                            got_reg   <= '0;
                            emit_reg  <= '0;
                            c_reg     <= '0;
                            state_reg <= ST_WALK;
                        end
                    endcase
                end
                ST_WALK:
                begin
                    rvld_reg <= 1'b0;
                    if (rd_reg < load_reg && !rvld_reg && got_reg == rd_reg)
                    begin
                        rd_reg   <= rd_reg + CntW'(1);
                        rvld_reg <= 1'b1;
                    end
                    if (exp_vld)
                    begin
                        c_reg     <= c_reg + 24'(exp_y);
                        got_reg   <= got_reg + CntW'(1);
                        nrun_reg  <= neff;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_reg < nrun_reg && slot_hit)
                    begin
                        res_vld_reg <= 1'b1;
                        res_reg.particle_index <= 6'(walk_idx);
                        res_reg.last_index <= (emit_reg + CntW'(1) == nrun_reg);
                        emit_reg <= emit_reg + CntW'(1);
                    end
                    else if (got_reg == load_reg)
                        state_reg <= ST_FILL;
                    else
                        state_reg <= ST_WALK;
                end
                default:
                begin
                    if (emit_reg < nrun_reg)
                    begin
                        res_vld_reg <= 1'b1;
                        res_reg.particle_index <= 6'(load_reg - CntW'(1));
                        res_reg.last_index <= (emit_reg + CntW'(1) == nrun_reg);
                        emit_reg <= emit_reg + CntW'(1);
                    end
                    else
                    begin
                        load_reg  <= '0;
                        max_reg   <= -16'sd32768;
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    `include "systematic_resampler_core_assert.svh"
    `SR_ASSERT_IMP(a_res_in_run, clk, rst_n, result_valid, busy)
    `SR_ASSERT_IMP(a_load_bound, clk, rst_n, 1'b1, load_reg <= CntW'(sresamp_pkg::MaxParticles))
    `SR_ASSERT_NXT(a_last_ends, clk, rst_n, result_valid && result.last_index, !result_valid)
endmodule
`default_nettype wire
